// ----- hdl/md5bk_pkg.sv -----
// Shared types, constants and MD5 round tables for the key derivation block.
package md5bk_pkg;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_RADDR,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } md5bk_state_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PW_LEN   = 3'd0,
    REG_SALT_LEN = 3'd1,
    REG_ROUNDS   = 3'd2,
    REG_KEY_LEN  = 3'd3,
    REG_IV_LEN   = 3'd4
  } md5bk_reg_t;

  localparam int CFG_AW       = 5;
  localparam int DIGEST_BYTES = 16;

  localparam logic [31:0] MD5_IV [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amount of a round
  function automatic logic [4:0] md5_s(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;
      4'd1:  s = 5'd12;
      4'd2:  s = 5'd17;
      4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;
      4'd5:  s = 5'd9;
      4'd6:  s = 5'd14;
      4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;
      4'd9:  s = 5'd11;
      4'd10: s = 5'd16;
      4'd11: s = 5'd23;
      4'd12: s = 5'd6;
      4'd13: s = 5'd10;
      4'd14: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word index of a round
  function automatic logic [3:0] md5_g(input logic [5:0] r);
    logic [8:0] t;
    case (r[5:4])
      2'd0:    t = 9'(r);
      2'd1:    t = 9'(r) * 9'd5 + 9'd1;
      2'd2:    t = 9'(r) * 9'd3 + 9'd5;
      default: t = 9'(r) * 9'd7;
    endcase
    return t[3:0];
  endfunction

endpackage

// ----- hdl/md5bk_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module md5bk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/md5_bytes_to_key_derivation.sv -----
// Top level: MD5-based key and IV derivation with byte-stream load and emit.
// Loading: one password or salt byte per cycle, in_tready high while idle.
// Each 64-byte MD5 block runs fill, first-word fetch, the rounds and a fold in that order; a digest
// is 1 or 2 blocks plus one block per extra round, then up to 16 of its bytes are emitted.
// Output bytes leave one per cycle during emit, via an output register, when out_tready is high.
// Reset (rst_n low, synchronous) returns to idle with default register values.
module md5_bytes_to_key_derivation #(
  parameter int MAX_PASSWORD_BYTES = 64,
  parameter int MAX_SALT_BYTES     = 16,
  parameter int MAX_OUTPUT_BYTES   = 48
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] in_byte
  input  logic                         in_tuser,   // [0] is_salt
  input  logic                         in_tlast,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [7:0]                   out_tdata,  // [7:0] out_byte
  output logic                         out_tuser,  // [0] is_iv
  output logic                         out_tlast,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [md5bk_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);

  localparam int PW   = $clog2(16 + MAX_PASSWORD_BYTES + MAX_SALT_BYTES + 128);
  localparam int LCW  = $clog2(MAX_PASSWORD_BYTES + MAX_SALT_BYTES + 1);
  localparam int BD   = MAX_PASSWORD_BYTES + MAX_SALT_BYTES;
  localparam int BAW  = $clog2(BD);
  localparam int LBW  = PW + 3;

  // Registers
  md5bk_pkg::md5bk_state_t state_r, state_nxt;
  logic [6:0]   pl_r, pl_nxt;
  logic [4:0]   sl_r, sl_nxt;
  logic [15:0]  hr_r, hr_nxt;
  logic [5:0]   kl_r, kl_nxt;
  logic [4:0]   il_r, il_nxt;
  logic [LCW-1:0] lc_r, lc_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         st_v_r, st_v_nxt;
  logic [6:0]   fi_r, fi_nxt;
  logic [5:0]   rnd_r, rnd_nxt;
  logic [4:0]   di_r, di_nxt;
  logic [6:0]   epos_r, epos_nxt;
  logic [15:0]  rcnt_r, rcnt_nxt;

  logic [31:0]  a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, d_r, d_nxt;
  logic [3:0][31:0] h_r, h_nxt;
  logic [127:0] digest_r, digest_nxt;
  logic [23:0]  wacc_r, wacc_nxt;
  logic [5:0]   st_i_r, st_i_nxt;
  logic         st_ram_r, st_ram_nxt;
  logic [7:0]   st_val_r, st_val_nxt;
  logic [PW-1:0] blk_r, blk_nxt, mlen_r, mlen_nxt, pre_r, pre_nxt;
  logic [PW-1:0] plen_r, plen_nxt, slen_r, slen_nxt;
  logic [6:0]   klen_r, klen_nxt, need_r, need_nxt;
  logic [7:0]   ob_r, ob_nxt;
  logic         oiv_r, oiv_nxt, olast_r, olast_nxt;

  // Memory ports
  logic           b_we;
  logic [BAW-1:0] b_waddr, b_raddr;
  logic [7:0]     b_rdata;
  logic           m_we;
  logic [3:0]     m_waddr, m_raddr;
  logic [31:0]    m_wdata, m_rdata;

  // Derived values
  logic [PW-1:0]  plen_c, slen_c, p, pp, lc_w;
  logic [6:0]     klen_c, vlen_c, rem_c, need_c;
  logic [15:0]    rounds_c;
  logic           lastblk, cfg_wr, in_acc, out_free;
  logic [LBW-1:0] lbits;
  logic [7:0]     fill_byte, issue_val;
  logic           issue_ram;
  logic [BAW-1:0] issue_addr;
  logic [31:0]    f_c, t_c, rot_c;
  logic [63:0]    rot_w;
  logic [3:0][31:0] hsum;

  md5bk_ram #(.WIDTH(8), .DEPTH(BD)) u_bytes (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(in_tdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  md5bk_ram #(.WIDTH(32), .DEPTH(16)) u_block (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  // Clamp lengths
  assign plen_c = (PW'(pl_r) > PW'(MAX_PASSWORD_BYTES)) ? PW'(MAX_PASSWORD_BYTES) : PW'(pl_r);
  assign slen_c = (PW'(sl_r) > PW'(MAX_SALT_BYTES)) ? PW'(MAX_SALT_BYTES) : PW'(sl_r);
  assign klen_c = (7'(kl_r) > 7'(MAX_OUTPUT_BYTES)) ? 7'(MAX_OUTPUT_BYTES) : 7'(kl_r);
  assign rem_c  = 7'(MAX_OUTPUT_BYTES) - klen_c;
  assign vlen_c = (7'(il_r) > rem_c) ? rem_c : 7'(il_r);
  assign need_c = klen_c + vlen_c;
  assign rounds_c = (hr_r == 16'd0) ? 16'd1 : hr_r;

  // Byte store write on load
  assign in_tready = (state_r == md5bk_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign lc_w      = PW'(lc_r);
  always_comb begin
    b_we    = 1'b0;
    b_waddr = BAW'(lc_r);
    if (!in_tuser) begin
      b_we = in_acc && (lc_w < PW'(MAX_PASSWORD_BYTES));
    end else begin
      b_we    = in_acc && (lc_w >= plen_c) && (lc_w - plen_c < PW'(MAX_SALT_BYTES));
      b_waddr = BAW'(PW'(MAX_PASSWORD_BYTES) + lc_w - plen_c);
    end
  end

  // Classify the message byte at the fill position
  assign p       = blk_r + PW'(fi_r);
  assign pp      = p - pre_r;
  assign lastblk = (blk_r + PW'(64)) >= (mlen_r + PW'(9));
  assign lbits   = {mlen_r, 3'b000};
  always_comb begin
    issue_ram  = 1'b0;
    issue_val  = 8'h00;
    issue_addr = BAW'(pp);
    if (p < pre_r) begin
      issue_val = digest_r[{p[3:0], 3'b000} +: 8];
    end else if (p < mlen_r) begin
      issue_ram = 1'b1;
      if (pp >= plen_r) begin
        issue_addr = BAW'(PW'(MAX_PASSWORD_BYTES) + pp - plen_r);
      end
    end else if (p == mlen_r) begin
      issue_val = 8'h80;
    end else if (lastblk && fi_r >= 7'd56) begin
      issue_val = 8'(lbits >> {fi_r[2:0], 3'b000});
    end
  end
  assign b_raddr   = issue_addr;
  assign fill_byte = st_ram_r ? b_rdata : st_val_r;

  // Assemble message words
  always_comb begin
    wacc_nxt = wacc_r;
    m_we     = 1'b0;
    m_waddr  = st_i_r[5:2];
    m_wdata  = {fill_byte, wacc_r};
    if (st_v_r) begin
      case (st_i_r[1:0])
        2'd0:    wacc_nxt[7:0]   = fill_byte;
        2'd1:    wacc_nxt[15:8]  = fill_byte;
        2'd2:    wacc_nxt[23:16] = fill_byte;
        default: m_we = 1'b1;
      endcase
    end
  end

  // One MD5 round
  always_comb begin
    case (rnd_r[5:4])
      2'd0:    f_c = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f_c = (d_r & b_r) | (~d_r & c_r);
      2'd2:    f_c = b_r ^ c_r ^ d_r;
      default: f_c = c_r ^ (b_r | ~d_r);
    endcase
  end
  assign t_c   = a_r + f_c + md5bk_pkg::MD5_K[rnd_r] + m_rdata;
  assign rot_w = {t_c, t_c} << md5bk_pkg::md5_s(rnd_r);
  assign rot_c = rot_w[63:32];
  assign hsum[0] = h_r[0] + a_r;
  assign hsum[1] = h_r[1] + b_r;
  assign hsum[2] = h_r[2] + c_r;
  assign hsum[3] = h_r[3] + d_r;
  assign m_raddr = (state_r == md5bk_pkg::ST_ROUND) ? md5bk_pkg::md5_g(rnd_r + 6'd1)
                                                     : md5bk_pkg::md5_g(6'd0);

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  always_comb begin
    pl_nxt = pl_r;
    sl_nxt = sl_r;
    hr_nxt = hr_r;
    kl_nxt = kl_r;
    il_nxt = il_r;
    cfg_prdata = 32'd0;
    unique case (md5bk_pkg::md5bk_reg_t'(cfg_paddr[4:2]))
      md5bk_pkg::REG_PW_LEN: begin
        cfg_prdata = 32'(pl_r);
        if (cfg_wr) pl_nxt = cfg_pwdata[6:0];
      end
      md5bk_pkg::REG_SALT_LEN: begin
        cfg_prdata = 32'(sl_r);
        if (cfg_wr) sl_nxt = cfg_pwdata[4:0];
      end
      md5bk_pkg::REG_ROUNDS: begin
        cfg_prdata = 32'(hr_r);
        if (cfg_wr) hr_nxt = cfg_pwdata[15:0];
      end
      md5bk_pkg::REG_KEY_LEN: begin
        cfg_prdata = 32'(kl_r);
        if (cfg_wr) kl_nxt = cfg_pwdata[5:0];
      end
      md5bk_pkg::REG_IV_LEN: begin
        cfg_prdata = 32'(il_r);
        if (cfg_wr) il_nxt = cfg_pwdata[4:0];
      end
      default: cfg_prdata = 32'd0;
    endcase
  end

  // Next state and datapath control
  assign out_free = !out_valid_r || out_tready;
  always_comb begin
    state_nxt     = state_r;
    lc_nxt        = lc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    st_v_nxt      = 1'b0;
    fi_nxt        = fi_r;
    rnd_nxt       = rnd_r;
    di_nxt        = di_r;
    epos_nxt      = epos_r;
    rcnt_nxt      = rcnt_r;
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r;
    h_nxt      = h_r;
    digest_nxt = digest_r;
    st_i_nxt   = fi_r[5:0];
    st_ram_nxt = issue_ram;
    st_val_nxt = issue_val;
    blk_nxt  = blk_r;
    mlen_nxt = mlen_r;
    pre_nxt  = pre_r;
    plen_nxt = plen_r;
    slen_nxt = slen_r;
    klen_nxt = klen_r;
    need_nxt = need_r;
    ob_nxt = ob_r; oiv_nxt = oiv_r; olast_nxt = olast_r;
    unique case (state_r)
      md5bk_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (lc_w < PW'(BD)) lc_nxt = lc_r + LCW'(1);
          if (in_tlast) begin
            lc_nxt   = '0;
            plen_nxt = plen_c;
            slen_nxt = slen_c;
            klen_nxt = klen_c;
            need_nxt = need_c;
            epos_nxt = '0;
            rcnt_nxt = rounds_c;
            pre_nxt  = '0;
            mlen_nxt = plen_c + slen_c;
            blk_nxt  = '0;
            fi_nxt   = '0;
            h_nxt    = {md5bk_pkg::MD5_IV[3], md5bk_pkg::MD5_IV[2],
                        md5bk_pkg::MD5_IV[1], md5bk_pkg::MD5_IV[0]};
            a_nxt = md5bk_pkg::MD5_IV[0]; b_nxt = md5bk_pkg::MD5_IV[1];
            c_nxt = md5bk_pkg::MD5_IV[2]; d_nxt = md5bk_pkg::MD5_IV[3];
            if (need_c != 7'd0) state_nxt = md5bk_pkg::ST_FILL;
          end
        end
      end
      md5bk_pkg::ST_FILL: begin
        if (fi_r == 7'd64) begin
          state_nxt = md5bk_pkg::ST_RADDR;
        end else begin
          st_v_nxt = 1'b1;
          fi_nxt   = fi_r + 7'd1;
        end
      end
      md5bk_pkg::ST_RADDR: begin
        rnd_nxt   = '0;
        state_nxt = md5bk_pkg::ST_ROUND;
      end
      md5bk_pkg::ST_ROUND: begin
        a_nxt   = d_r;
        d_nxt   = c_r;
        c_nxt   = b_r;
        b_nxt   = b_r + rot_c;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) state_nxt = md5bk_pkg::ST_FOLD;
      end
      md5bk_pkg::ST_FOLD: begin
        fi_nxt = '0;
        if (lastblk) begin
          digest_nxt = hsum;
          h_nxt      = {md5bk_pkg::MD5_IV[3], md5bk_pkg::MD5_IV[2],
                        md5bk_pkg::MD5_IV[1], md5bk_pkg::MD5_IV[0]};
          a_nxt = md5bk_pkg::MD5_IV[0]; b_nxt = md5bk_pkg::MD5_IV[1];
          c_nxt = md5bk_pkg::MD5_IV[2]; d_nxt = md5bk_pkg::MD5_IV[3];
          blk_nxt = '0;
          if (rcnt_r > 16'd1) begin
            // rehash the digest alone
            rcnt_nxt  = rcnt_r - 16'd1;
            pre_nxt   = PW'(md5bk_pkg::DIGEST_BYTES);
            mlen_nxt  = PW'(md5bk_pkg::DIGEST_BYTES);
            state_nxt = md5bk_pkg::ST_FILL;
          end else begin
            di_nxt    = '0;
            state_nxt = md5bk_pkg::ST_EMIT;
          end
        end else begin
          blk_nxt = blk_r + PW'(64);
          h_nxt   = hsum;
          a_nxt = hsum[0]; b_nxt = hsum[1]; c_nxt = hsum[2]; d_nxt = hsum[3];
          state_nxt = md5bk_pkg::ST_FILL;
        end
      end
      md5bk_pkg::ST_EMIT: begin
        if (out_free) begin
          if (di_r < 5'd16 && epos_r < need_r) begin
            out_valid_nxt = 1'b1;
            ob_nxt    = digest_r[{di_r[3:0], 3'b000} +: 8];
            oiv_nxt   = (epos_r >= klen_r);
            olast_nxt = (epos_r + 7'd1 == need_r);
            di_nxt    = di_r + 5'd1;
            epos_nxt  = epos_r + 7'd1;
          end else if (epos_r == need_r) begin
            state_nxt = md5bk_pkg::ST_IDLE;
          end else begin
            // next digest over previous digest, password and salt
            rcnt_nxt  = rounds_c;
            pre_nxt   = PW'(md5bk_pkg::DIGEST_BYTES);
            mlen_nxt  = PW'(md5bk_pkg::DIGEST_BYTES) + plen_r + slen_r;
            blk_nxt   = '0;
            fi_nxt    = '0;
            state_nxt = md5bk_pkg::ST_FILL;
          end
        end
      end
      default: state_nxt = md5bk_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= md5bk_pkg::ST_IDLE;
      pl_r        <= 7'd0;
      sl_r        <= 5'd8;
      hr_r        <= 16'd1;
      kl_r        <= 6'd16;
      il_r        <= 5'd16;
      lc_r        <= '0;
      out_valid_r <= 1'b0;
      st_v_r      <= 1'b0;
      fi_r        <= '0;
      rnd_r       <= '0;
      di_r        <= '0;
      epos_r      <= '0;
      rcnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      pl_r        <= pl_nxt;
      sl_r        <= sl_nxt;
      hr_r        <= hr_nxt;
      kl_r        <= kl_nxt;
      il_r        <= il_nxt;
      lc_r        <= lc_nxt;
      out_valid_r <= out_valid_nxt;
      st_v_r      <= st_v_nxt;
      fi_r        <= fi_nxt;
      rnd_r       <= rnd_nxt;
      di_r        <= di_nxt;
      epos_r      <= epos_nxt;
      rcnt_r      <= rcnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    c_r      <= c_nxt;
    d_r      <= d_nxt;
    h_r      <= h_nxt;
    digest_r <= digest_nxt;
    wacc_r   <= wacc_nxt;
    st_i_r   <= st_i_nxt;
    st_ram_r <= st_ram_nxt;
    st_val_r <= st_val_nxt;
    blk_r    <= blk_nxt;
    mlen_r   <= mlen_nxt;
    pre_r    <= pre_nxt;
    plen_r   <= plen_nxt;
    slen_r   <= slen_nxt;
    klen_r   <= klen_nxt;
    need_r   <= need_nxt;
    ob_r     <= ob_nxt;
    oiv_r    <= oiv_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = ob_r;
  assign out_tuser  = oiv_r;
  assign out_tlast  = olast_r;

endmodule

// ----- hdl/md5bk_checker.sv -----
// Port-level checker for the key derivation block, bound to the top level.
module md5bk_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // Hold a stalled request
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out data changed while stalled");

  // Nothing follows the final derived byte without new input
  a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("output after final byte");

  // Loading continues until the final input byte
  a_keep_loading: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast |=> in_tready)
    else $error("input stalled mid-load");

endmodule

bind md5_bytes_to_key_derivation md5bk_checker u_md5bk_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tlast(in_tlast), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tlast(out_tlast)
);
